### src/cau_pkg.sv
// Package for the complex arithmetic unit: operation codes, item/result types
// and the shared saturation and divider-step functions. No dependencies.
`timescale 1ns / 1ps

package cau_pkg;

    localparam int CAU_FRAC_BITS   = 16;
    localparam int CAU_QUEUE_DEPTH = 4;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_EQ  = 4'd4;
    localparam logic [3:0] OP_NE  = 4'd5;
    localparam logic [3:0] OP_GT  = 4'd6;
    localparam logic [3:0] OP_LT  = 4'd7;
    localparam logic [3:0] OP_GE  = 4'd8;
    localparam logic [3:0] OP_LE  = 4'd9;

    // divider quotient cap, 2^40
    localparam logic [40:0] QUOT_CAP = 41'h100_0000_0000;

    typedef enum logic [3:0] {
        CLS_ADD, CLS_SUB, CLS_MUL, CLS_DIV, CLS_EQ, CLS_NE,
        CLS_GT, CLS_LT, CLS_GE, CLS_LE, CLS_NOP
    } t_cls;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    typedef struct packed {
        t_cls               cls;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } t_item;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        cmp;
        t_status     status;
    } t_res;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_sat;

    // one lane of the restoring divider
    typedef struct packed {
        logic        neg;
        logic [63:0] r;
        logic [40:0] q;
        logic        big;
        logic [63:0] mag;
    } t_lane;

    function automatic t_sat sat_pack(input logic neg, input logic [63:0] q);
        t_sat s;
        s.sat = 1'b0;
        if (!neg) begin
            if (q > 64'h7FFF_FFFF) begin
                s.sat = 1'b1;
                s.val = 32'h7FFF_FFFF;
            end else begin
                s.val = q[31:0];
            end
        end else begin
            if (q > 64'h8000_0000) begin
                s.sat = 1'b1;
                s.val = 32'h8000_0000;
            end else begin
                s.val = 32'(0) - q[31:0];
            end
        end
        return s;
    endfunction

    function automatic t_sat add_sat(input logic signed [32:0] s);
        t_sat o;
        o.sat = s[32] != s[31];
        if (o.sat) begin
            o.val = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            o.val = s[31:0];
        end
        return o;
    endfunction

    function automatic t_lane div_step(input t_lane l, input logic [63:0] den);
        t_lane       n;
        logic [63:0] rs;
        n      = l;
        rs     = {l.r[62:0], l.mag[63]};
        n.mag  = {l.mag[62:0], 1'b0};
        if (l.q >= QUOT_CAP) begin
            n.big = 1'b1;
        end else begin
            n.q = {l.q[39:0], 1'b0};
        end
        if (rs >= den) begin
            n.r = rs - den;
            if (!n.big) begin
                n.q[0] = 1'b1;
            end
        end else begin
            n.r = rs;
        end
        return n;
    endfunction

    // round to nearest, ties away, then clamp
    function automatic t_sat div_finish(input t_lane l, input logic [63:0] den);
        logic [41:0] qf;
        if (l.big) begin
            qf = {1'b0, QUOT_CAP};
        end else begin
            qf = {1'b0, l.q} + 42'(({l.r, 1'b0} >= {1'b0, den}) ? 1 : 0);
        end
        return sat_pack(l.neg, 64'(qf));
    endfunction

endpackage

### src/cau_front.sv
// Front end: takes input beats and classifies the operation code.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_front import cau_pkg::*; (
    input  logic               i_push,
    input  logic               i_q_full,
    input  logic [3:0]         i_operation,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               o_full,
    output logic               o_wr,
    output t_item              o_item
);

    t_cls cls;

    always_comb begin
        unique case (i_operation)
            OP_ADD:  cls = CLS_ADD;
            OP_SUB:  cls = CLS_SUB;
            OP_MUL:  cls = CLS_MUL;
            OP_DIV:  cls = CLS_DIV;
            OP_EQ:   cls = CLS_EQ;
            OP_NE:   cls = CLS_NE;
            OP_GT:   cls = CLS_GT;
            OP_LT:   cls = CLS_LT;
            OP_GE:   cls = CLS_GE;
            OP_LE:   cls = CLS_LE;
            default: cls = CLS_NOP;
        endcase
    end

    assign o_full      = i_q_full;
    assign o_wr        = i_push && !i_q_full;
    assign o_item.cls  = cls;
    assign o_item.a_re = i_a_re;
    assign o_item.a_im = i_a_im;
    assign o_item.b_re = i_b_re;
    assign o_item.b_im = i_b_im;

endmodule

### src/cau_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_queue import cau_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_item i_item,
    input  logic  i_rd,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    localparam int AW = $clog2(CAU_QUEUE_DEPTH);

    t_item         r_mem [CAU_QUEUE_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_rd) begin
                r_rd <= r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_wr) - (AW+1)'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_full  = r_cnt == (AW+1)'(CAU_QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_item  = r_mem[r_rd];

endmodule

### src/cau_div.sv
// Pipelined restoring divider, two lanes sharing one denominator, one
// quotient bit per stage; other results ride along. Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_div import cau_pkg::*; #(
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ce,
    input  logic        i_valid,
    input  logic        i_do_div,
    input  logic [63:0] i_den,
    input  logic        i_neg_re,
    input  logic [63:0] i_mag_re,
    input  logic        i_neg_im,
    input  logic [63:0] i_mag_im,
    input  t_res        i_res,
    output logic        o_valid,
    output t_res        o_res
);

    localparam int STEPS = 64 + FRAC_BITS;

    typedef struct packed {
        logic        do_div;
        logic [63:0] den;
        t_lane       re;
        t_lane       im;
        t_res        res;
    } t_dstage;

    t_dstage r_st [STEPS];
    t_dstage n_st [STEPS];
    logic    r_v  [STEPS];
    t_dstage first;
    t_sat    fin_re;
    t_sat    fin_im;

    always_comb begin
        first.do_div = i_do_div;
        first.den    = i_den;
        first.res    = i_res;
        first.re     = '{neg: i_neg_re, r: '0, q: '0, big: 1'b0, mag: i_mag_re};
        first.im     = '{neg: i_neg_im, r: '0, q: '0, big: 1'b0, mag: i_mag_im};
    end

    always_comb begin
        n_st[0]    = first;
        n_st[0].re = div_step(first.re, first.den);
        n_st[0].im = div_step(first.im, first.den);
        for (int i = 1; i < STEPS; i++) begin
            n_st[i]    = r_st[i-1];
            n_st[i].re = div_step(r_st[i-1].re, r_st[i-1].den);
            n_st[i].im = div_step(r_st[i-1].im, r_st[i-1].den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STEPS; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (i_ce) begin
            r_v[0] <= i_valid;
            for (int i = 1; i < STEPS; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < STEPS; i++) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    assign fin_re  = div_finish(r_st[STEPS-1].re, r_st[STEPS-1].den);
    assign fin_im  = div_finish(r_st[STEPS-1].im, r_st[STEPS-1].den);
    assign o_valid = r_v[STEPS-1];

    always_comb begin
        if (r_st[STEPS-1].do_div) begin
            o_res.re     = fin_re.val;
            o_res.im     = fin_im.val;
            o_res.cmp    = 1'b0;
            o_res.status = (fin_re.sat || fin_im.sat) ? ST_SAT : ST_OK;
        end else begin
            o_res = r_st[STEPS-1].res;
        end
    end

endmodule

### src/cau_back.sv
// Back end: products, sums, compares and rounding in a stalling pipeline,
// then the divider and the output register. Depends on cau_pkg, cau_div.
`timescale 1ns / 1ps

module cau_back import cau_pkg::*; #(
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_q_empty,
    input  t_item       i_q_item,
    output logic        o_q_rd,
    input  logic        i_pop,
    output logic        o_empty,
    output t_res        o_res
);

    localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

    logic        ce;
    logic [7:0]  r_tol;

    // stage 0: operand register
    logic        r0_v;
    t_item       r0;

    // stage 1: products and short sums
    logic               r1_v;
    t_cls               r1_cls;
    logic signed [63:0] r1_p_rr, r1_p_ii, r1_p_ri, r1_p_ir;
    logic signed [63:0] r1_sq_ar, r1_sq_ai, r1_sq_br, r1_sq_bi;
    logic signed [32:0] r1_s_re, r1_s_im, r1_d_re, r1_d_im;

    // stage 2: wide sums
    logic               r2_v;
    t_cls               r2_cls;
    logic signed [64:0] r2_t_re, r2_t_im;
    logic [63:0]        r2_den, r2_ma, r2_mb;
    logic               r2_eq;
    t_res               r2_add;

    // stage 3: sign and magnitude, compare outcome
    logic        r3_v;
    t_cls        r3_cls;
    logic        r3_neg_re, r3_neg_im;
    logic [63:0] r3_mag_re, r3_mag_im, r3_den;
    logic        r3_cmp;
    t_res        r3_add;

    logic        r_out_v;
    t_res        r_out;

    logic signed [64:0] n_t_re, n_t_im;
    logic [32:0]        adr, adi;
    t_sat               as_re, as_im, ms_re, ms_im;
    logic               n_cmp;
    logic               d_do_div;
    t_res               d_res;
    logic               div_v;
    t_res               div_res;

    assign ce     = !r_out_v || i_pop;
    assign o_q_rd = ce && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_wr) begin
            r_tol <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v    <= 1'b0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (ce) begin
            r0_v    <= !i_q_empty;
            r1_v    <= r0_v;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_out_v <= div_v;
        end
    end

    // stage 2 combinational terms
    always_comb begin
        unique case (r1_cls)
            CLS_DIV: begin
                n_t_re = 65'(r1_p_rr) + 65'(r1_p_ii);
                n_t_im = 65'(r1_p_ir) - 65'(r1_p_ri);
            end
            default: begin
                n_t_re = 65'(r1_p_rr) - 65'(r1_p_ii);
                n_t_im = 65'(r1_p_ri) + 65'(r1_p_ir);
            end
        endcase
        adr   = r1_d_re[32] ? 33'(-r1_d_re) : 33'(r1_d_re);
        adi   = r1_d_im[32] ? 33'(-r1_d_im) : 33'(r1_d_im);
        as_re = add_sat(r1_s_re);
        as_im = add_sat(r1_s_im);
    end

    // stage 3 compare outcome
    always_comb begin
        unique case (r2_cls)
            CLS_EQ:  n_cmp = r2_eq;
            CLS_NE:  n_cmp = !r2_eq;
            CLS_GT:  n_cmp = r2_ma > r2_mb;
            CLS_LT:  n_cmp = r2_ma < r2_mb;
            CLS_GE:  n_cmp = r2_eq || (r2_ma > r2_mb);
            CLS_LE:  n_cmp = r2_eq || (r2_ma < r2_mb);
            default: n_cmp = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r0 <= i_q_item;

            r1_cls   <= r0.cls;
            r1_p_rr  <= r0.a_re * r0.b_re;
            r1_p_ii  <= r0.a_im * r0.b_im;
            r1_p_ri  <= r0.a_re * r0.b_im;
            r1_p_ir  <= r0.a_im * r0.b_re;
            r1_sq_ar <= r0.a_re * r0.a_re;
            r1_sq_ai <= r0.a_im * r0.a_im;
            r1_sq_br <= r0.b_re * r0.b_re;
            r1_sq_bi <= r0.b_im * r0.b_im;
            r1_d_re  <= 33'(r0.a_re) - 33'(r0.b_re);
            r1_d_im  <= 33'(r0.a_im) - 33'(r0.b_im);
            if (r0.cls == CLS_SUB) begin
                r1_s_re <= 33'(r0.a_re) - 33'(r0.b_re);
                r1_s_im <= 33'(r0.a_im) - 33'(r0.b_im);
            end else begin
                r1_s_re <= 33'(r0.a_re) + 33'(r0.b_re);
                r1_s_im <= 33'(r0.a_im) + 33'(r0.b_im);
            end

            r2_cls            <= r1_cls;
            r2_t_re           <= n_t_re;
            r2_t_im           <= n_t_im;
            r2_den            <= 64'(r1_sq_br) + 64'(r1_sq_bi);
            r2_ma             <= 64'(r1_sq_ar) + 64'(r1_sq_ai);
            r2_mb             <= 64'(r1_sq_br) + 64'(r1_sq_bi);
            r2_eq             <= (adr <= 33'(r_tol)) && (adi <= 33'(r_tol));
            r2_add.re         <= as_re.val;
            r2_add.im         <= as_im.val;
            r2_add.cmp        <= 1'b0;
            r2_add.status     <= (as_re.sat || as_im.sat) ? ST_SAT : ST_OK;

            r3_cls    <= r2_cls;
            r3_neg_re <= r2_t_re[64];
            r3_neg_im <= r2_t_im[64];
            r3_mag_re <= r2_t_re[64] ? 64'(-r2_t_re) : r2_t_re[63:0];
            r3_mag_im <= r2_t_im[64] ? 64'(-r2_t_im) : r2_t_im[63:0];
            r3_den    <= r2_den;
            r3_cmp    <= n_cmp;
            r3_add    <= r2_add;

            r_out <= div_res;
        end
    end

    // multiply rounding and result selection ahead of the divider
    always_comb begin
        ms_re    = sat_pack(r3_neg_re, (r3_mag_re + HALF) >> FRAC_BITS);
        ms_im    = sat_pack(r3_neg_im, (r3_mag_im + HALF) >> FRAC_BITS);
        d_do_div = 1'b0;
        d_res    = '{re: '0, im: '0, cmp: 1'b0, status: ST_OK};
        unique case (r3_cls)
            CLS_ADD, CLS_SUB: d_res = r3_add;
            CLS_MUL: begin
                d_res.re     = ms_re.val;
                d_res.im     = ms_im.val;
                d_res.status = (ms_re.sat || ms_im.sat) ? ST_SAT : ST_OK;
            end
            CLS_DIV: begin
                if (r3_den == '0) begin
                    d_res.status = ST_DIVZ;
                end else begin
                    d_do_div = 1'b1;
                end
            end
            CLS_EQ, CLS_NE, CLS_GT, CLS_LT, CLS_GE, CLS_LE: d_res.cmp = r3_cmp;
            default: d_res.cmp = 1'b0;
        endcase
    end

    cau_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (ce),
        .i_valid  (r3_v),
        .i_do_div (d_do_div),
        .i_den    (r3_den),
        .i_neg_re (r3_neg_re),
        .i_mag_re (r3_mag_re),
        .i_neg_im (r3_neg_im),
        .i_mag_im (r3_mag_im),
        .i_res    (d_res),
        .o_valid  (div_v),
        .o_res    (div_res)
    );

    assign o_empty = !r_out_v;
    assign o_res   = r_out;

endmodule

### src/complex_arithmetic_unit.sv
// Complex arithmetic unit on signed fixed-point operands.
//
// Input side is a queue: present operation and operands with push while full
// is low; each such edge takes one beat. Result side is a queue too: while
// empty is low the oldest result sits on o_res_*, o_compare_true, o_status,
// and pop with empty low takes it. The tolerance register is written through
// valid/ready (ready is always high); the user must write it only while the
// unit is idle, which the block itself does not enforce. Throughput is one
// beat per cycle for every operation while the result side does not stall.
// All operations pass through the divider pipeline, one quotient bit per
// stage, so results stay in order.
// When the result side stalls, the whole back pipeline holds and the four
// entry front queue fills, then full rises. Reset empties everything and
// clears the tolerance to zero.
// Depends on cau_pkg, cau_front, cau_queue, cau_back.
`timescale 1ns / 1ps

module complex_arithmetic_unit import cau_pkg::*; #(
    parameter int FRAC_BITS = CAU_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         i_operation,
    input  logic signed [31:0] i_a_re,
    input  logic signed [31:0] i_a_im,
    input  logic signed [31:0] i_b_re,
    input  logic signed [31:0] i_b_im,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] o_res_re,
    output logic signed [31:0] o_res_im,
    output logic               o_compare_true,
    output logic [1:0]         o_status,
    input  logic               valid,
    output logic               ready,
    input  logic [7:0]         i_equal_tolerance
);

    logic  q_full, q_empty, q_wr, q_rd;
    t_item f_item, q_item;
    t_res  res;

    assign ready = 1'b1;

    cau_front u_front (
        .i_push      (push),
        .i_q_full    (q_full),
        .i_operation (i_operation),
        .i_a_re      (i_a_re),
        .i_a_im      (i_a_im),
        .i_b_re      (i_b_re),
        .i_b_im      (i_b_im),
        .o_full      (full),
        .o_wr        (q_wr),
        .o_item      (f_item)
    );

    cau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_item  (f_item),
        .i_rd    (q_rd),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (valid && ready),
        .i_cfg_data (i_equal_tolerance),
        .i_q_empty  (q_empty),
        .i_q_item   (q_item),
        .o_q_rd     (q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_res      (res)
    );

    assign o_res_re       = res.re;
    assign o_res_im       = res.im;
    assign o_compare_true = res.cmp;
    assign o_status       = res.status;

endmodule
